>>> rtl/bdch_pkg.sv
// ----------------------------------------------------------------------------
// bdch_pkg
// Types and constants shared by the button debounce, click and hold block.
// ----------------------------------------------------------------------------
package bdch_pkg;

	localparam int unsigned TIME_W  = 16;
	localparam int unsigned TICKS_W = 8;
	localparam int unsigned COUNT_W = TIME_W + 1;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [TIME_W-1:0] DEBOUNCE_TIME_RST       = 16'd0;
	localparam logic [TIME_W-1:0] HOLD_TIME_RST           = 16'd1000;
	localparam logic [TIME_W-1:0] DOUBLE_CLICK_WINDOW_RST = 16'd300;
	localparam logic              INITIAL_LEVEL_RST       = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE_TIME       = 2'd0,
		REG_HOLD_TIME           = 2'd1,
		REG_DOUBLE_CLICK_WINDOW = 2'd2,
		REG_INITIAL_LEVEL       = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic               raw_level;
		logic [TICKS_W-1:0] ticks_elapsed;
	} poll_item_t;

	typedef struct packed {
		logic level_changed;
		logic new_level;
		logic clicked;
		logic double_clicked;
		logic held;
	} report_item_t;

	typedef struct packed {
		logic step;
		logic init_we;
		logic init_val;
	} bdch_ctl_t;

endpackage

>>> rtl/bdch_poll_if.sv
// ----------------------------------------------------------------------------
// bdch_poll_if
// Channel that carries one poll of the raw switch level per beat.
// ----------------------------------------------------------------------------
interface bdch_poll_if;
	logic       valid;
	logic       ready;
	logic       raw_level;
	logic [7:0] ticks_elapsed;

	modport source (output valid, output raw_level, output ticks_elapsed, input ready);
	modport sink (input valid, input raw_level, input ticks_elapsed, output ready);
endinterface

>>> rtl/bdch_report_if.sv
// ----------------------------------------------------------------------------
// bdch_report_if
// Channel that carries the debounced level and button events, one per beat.
// ----------------------------------------------------------------------------
interface bdch_report_if;
	logic valid;
	logic ready;
	logic level_changed;
	logic new_level;
	logic clicked;
	logic double_clicked;
	logic held;

	modport source (
		output valid, output level_changed, output new_level, output clicked,
		output double_clicked, output held, input ready
	);
	modport sink (
		input valid, input level_changed, input new_level, input clicked,
		input double_clicked, input held, output ready
	);
endinterface

>>> rtl/bdch_core.sv
// ----------------------------------------------------------------------------
// bdch_core
// Button state and the single-pass update for one poll: debounce lockout,
// hold timer and double-click window.
// ----------------------------------------------------------------------------
module bdch_core
	import bdch_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  bdch_ctl_t           ctl,
	input  poll_item_t          item,
	input  logic [TIME_W-1:0]   debounce_time,
	input  logic [TIME_W-1:0]   hold_time,
	input  logic [TIME_W-1:0]   double_click_window,
	output report_item_t        result
);

	logic               stable_q, stable_n;
	logic [COUNT_W-1:0] debounce_count_q, debounce_count_n;
	logic [COUNT_W-1:0] hold_count_q, hold_count_n;
	logic               hold_fired_q, hold_fired_n;
	logic               click_pending_q, click_pending_n;
	logic [COUNT_W-1:0] window_count_q, window_count_n;
	logic [COUNT_W-1:0] ticks;

	always_comb begin
		ticks            = {{(COUNT_W-TICKS_W){1'b0}}, item.ticks_elapsed};
		stable_n         = stable_q;
		debounce_count_n = debounce_count_q;
		hold_count_n     = hold_count_q;
		hold_fired_n     = hold_fired_q;
		click_pending_n  = click_pending_q;
		window_count_n   = window_count_q;
		result           = '0;

		if (debounce_count_q < {1'b0, debounce_time}) begin
			debounce_count_n = debounce_count_q + ticks;
		end else if (item.raw_level != stable_q) begin
			if (item.raw_level) begin
				if (!click_pending_q) begin
					click_pending_n = 1'b1;
					hold_count_n    = '0;
					hold_fired_n    = 1'b0;
					window_count_n  = '0;
				end else if (window_count_q < {1'b0, double_click_window}) begin
					click_pending_n       = 1'b0;
					result.double_clicked = 1'b1;
				end
			end
			result.level_changed = 1'b1;
			stable_n             = item.raw_level;
			debounce_count_n     = '0;
		end

		if (stable_n) begin
			if (hold_count_n < {1'b0, hold_time}) begin
				hold_count_n = hold_count_n + ticks;
			end else if (!hold_fired_n) begin
				result.held  = 1'b1;
				hold_fired_n = 1'b1;
			end
		end

		if (window_count_n < {1'b0, double_click_window}) begin
			window_count_n = window_count_n + ticks;
		end else if (click_pending_n && !stable_n) begin
			result.clicked  = !hold_fired_n;
			click_pending_n = 1'b0;
		end

		result.new_level = stable_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q         <= INITIAL_LEVEL_RST;
			debounce_count_q <= '0;
			hold_count_q     <= '0;
			hold_fired_q     <= 1'b0;
			click_pending_q  <= 1'b0;
			window_count_q   <= '0;
		end else if (ctl.step) begin
			stable_q         <= stable_n;
			debounce_count_q <= debounce_count_n;
			hold_count_q     <= hold_count_n;
			hold_fired_q     <= hold_fired_n;
			click_pending_q  <= click_pending_n;
			window_count_q   <= window_count_n;
		end else if (ctl.init_we) begin
			stable_q <= ctl.init_val;
		end
	end

endmodule

>>> rtl/button_debounce_click_hold.sv
// ----------------------------------------------------------------------------
// button_debounce_click_hold
// An accepted poll is registered in item_s1, and its result in out_q.
// Throughput: one poll per cycle if report is not stalled (single-pass core).
// Reset: arst_n clears all counters and event state, sets the stable level to
// released and loads the register reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module button_debounce_click_hold
	import bdch_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	bdch_poll_if.sink             poll,
	bdch_report_if.source         report,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [TIME_W-1:0]     cfg_data
);

	logic [TIME_W-1:0] debounce_time_q;
	logic [TIME_W-1:0] hold_time_q;
	logic [TIME_W-1:0] double_click_window_q;

	logic         valid_s1;
	poll_item_t   item_s1;
	logic         adv_s1;
	logic         out_valid_q;
	report_item_t out_q;
	report_item_t result;
	bdch_ctl_t    ctl;

	assign adv_s1     = valid_s1 && (!out_valid_q || report.ready);
	assign poll.ready = !valid_s1 || adv_s1;

	assign ctl.step     = adv_s1;
	assign ctl.init_we  = cfg_we && (cfg_index == REG_INITIAL_LEVEL);
	assign ctl.init_val = cfg_data[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_time_q       <= DEBOUNCE_TIME_RST;
			hold_time_q           <= HOLD_TIME_RST;
			double_click_window_q <= DOUBLE_CLICK_WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE_TIME:       debounce_time_q       <= cfg_data;
				REG_HOLD_TIME:           hold_time_q           <= cfg_data;
				REG_DOUBLE_CLICK_WINDOW: double_click_window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.valid && poll.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			item_s1.raw_level     <= poll.raw_level;
			item_s1.ticks_elapsed <= poll.ticks_elapsed;
		end
	end

	bdch_core u_core (
		.clk                 (clk),
		.arst_n              (arst_n),
		.ctl                 (ctl),
		.item                (item_s1),
		.debounce_time       (debounce_time_q),
		.hold_time           (hold_time_q),
		.double_click_window (double_click_window_q),
		.result              (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q <= result;
		end
	end

	assign report.valid          = out_valid_q;
	assign report.level_changed  = out_q.level_changed;
	assign report.new_level      = out_q.new_level;
	assign report.clicked        = out_q.clicked;
	assign report.double_clicked = out_q.double_clicked;
	assign report.held           = out_q.held;

`ifndef SYNTHESIS
	a_dbl_is_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.double_clicked |-> out_q.level_changed && out_q.new_level)
		else $error("double click reported without an accepted press");

	a_held_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.held |-> out_q.new_level && !out_q.clicked)
		else $error("hold reported while released or together with a click");

	a_click_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.clicked |-> !out_q.new_level && !out_q.double_clicked)
		else $error("click reported while pressed or with a double click");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid_q)
		else $error("processed poll did not produce a result");
`endif

endmodule
